FILE: hdl/lpfr_pkg.sv
// Shared widths, codes, reset values and the result record of the frame receiver.
`timescale 1ns / 1ps

package lpfr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned EVENT_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // result event codes
   localparam logic [EVENT_W-1:0] EV_HEADER = 2'd0;
   localparam logic [EVENT_W-1:0] EV_DATA   = 2'd1;
   localparam logic [EVENT_W-1:0] EV_FAIL   = 2'd2;
   localparam logic [EVENT_W-1:0] EV_DROP   = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESSAGE_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_IDLE      = 2'd2;

   // configuration reset values
   localparam logic [BYTE_W-1:0] MAX_LENGTH_RST      = 8'd64;
   localparam logic [TICK_W-1:0] MESSAGE_TIMEOUT_RST = 16'd1000;
   localparam logic [TICK_W-1:0] FLUSH_IDLE_RST      = 16'd100;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [BYTE_W-1:0]  frame_length;
      logic [BYTE_W-1:0]  command;
      logic [BYTE_W-1:0]  data_byte;
      logic [BYTE_W-1:0]  byte_index;
      logic               last;
   } rsp_type;

endpackage

FILE: hdl/lpfr_if.sv
// Valid/ready channel interfaces for the frame receiver: input, result and register write.
`timescale 1ns / 1ps

interface lpfr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [lpfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface lpfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpfr_pkg::EVENT_W-1:0]  event_res;
   logic [lpfr_pkg::BYTE_W-1:0]   frame_length;
   logic [lpfr_pkg::BYTE_W-1:0]   command;
   logic [lpfr_pkg::BYTE_W-1:0]   data_byte;
   logic [lpfr_pkg::BYTE_W-1:0]   byte_index;
   logic                          last;

   modport source (output valid, output event_res, output frame_length, output command,
                   output data_byte, output byte_index, output last, input ready);
   modport sink   (input valid, input event_res, input frame_length, input command,
                   input data_byte, input byte_index, input last, output ready);
endinterface

interface lpfr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lpfr_pkg::CSR_IDX_W-1:0]   index;
   logic [lpfr_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/length_prefixed_frame_receiver_core.sv
// Length-prefixed frame receiver: decodes length/command/payload frames with timeouts.
//
// Channels:
//   req_ch  received bytes (kind = 0) and 100 us ticks (kind = 1), one per transaction.
//   rsp_ch  header, data, message-timeout and dropped-frame results; zero or one result
//           per input transaction, in input order.
//   csr_ch  register writes (max_length, message_timeout_ticks, flush_idle_ticks);
//           always ready, writes to unused indexes are ignored.
// Throughput: one input transaction per cycle while req_ch is ready. The frame state
// is updated in the same cycle the transaction is taken.
// A result is registered in the output register, or in the skid register while the
// output register holds one that rsp_ch does not take. An output register plus one
// skid register decouple the two sides: req_ch stays ready while a result waits,
// and drops ready only when both hold a result that rsp_ch has not taken.
// Reset: synchronous, active high; returns to idle, empties the result registers and
// loads the register reset values (64, 1000, 100).
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_core (
   input logic         clock,
   input logic         reset,
   lpfr_req_if.sink    req_ch,
   lpfr_rsp_if.source  rsp_ch,
   lpfr_csr_if.sink    csr_ch
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CMD   = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;
   localparam logic [1:0] MODE_FLUSH = 2'd3;

   logic [1:0]                    mode_ff, mode_in;
   logic [lpfr_pkg::BYTE_W-1:0]   held_length_ff, held_length_in;
   logic [lpfr_pkg::BYTE_W-1:0]   bytes_taken_ff, bytes_taken_in;
   logic [lpfr_pkg::TICK_W-1:0]   tick_count_ff, tick_count_in;

   logic [lpfr_pkg::BYTE_W-1:0]   max_length_ff;
   logic [lpfr_pkg::TICK_W-1:0]   message_timeout_ff;
   logic [lpfr_pkg::TICK_W-1:0]   flush_idle_ff;

   logic                          out_valid_ff, out_valid_in;
   lpfr_pkg::rsp_type             out_ff, out_in;
   logic                          skid_valid_ff, skid_valid_in;
   lpfr_pkg::rsp_type             skid_ff, skid_in;

   logic                          req_fire;
   logic                          rsp_fire;
   logic                          res_valid;
   lpfr_pkg::rsp_type             res;
   logic [lpfr_pkg::TICK_W-1:0]   tick_sat;
   logic [lpfr_pkg::BYTE_W-1:0]   taken_next;

   assign req_ch.ready = ~skid_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign rsp_fire     = rsp_ch.valid & rsp_ch.ready;

   assign tick_sat   = (tick_count_ff == '1) ? tick_count_ff
                                             : tick_count_ff + lpfr_pkg::TICK_W'(1);
   assign taken_next = bytes_taken_ff + lpfr_pkg::BYTE_W'(1);

   // frame decode for the transaction taken this cycle
   always_comb begin
      mode_in        = mode_ff;
      held_length_in = held_length_ff;
      bytes_taken_in = bytes_taken_ff;
      tick_count_in  = tick_count_ff;
      res_valid      = 1'b0;
      res.event_res    = lpfr_pkg::EV_HEADER;
      res.frame_length = held_length_ff;
      res.command      = '0;
      res.data_byte    = '0;
      res.byte_index   = '0;
      res.last         = 1'b0;
      if (req_fire) begin
         if (req_ch.kind) begin
            if (mode_ff == MODE_CMD || mode_ff == MODE_DATA) begin
               tick_count_in = tick_sat;
               if (tick_sat >= message_timeout_ff) begin
                  res_valid     = 1'b1;
                  res.event_res = lpfr_pkg::EV_FAIL;
                  mode_in       = MODE_IDLE;
               end
            end else if (mode_ff == MODE_FLUSH) begin
               tick_count_in = tick_sat;
               if (tick_sat >= flush_idle_ff) begin
                  res_valid     = 1'b1;
                  res.event_res = lpfr_pkg::EV_DROP;
                  mode_in       = MODE_IDLE;
               end
            end
         end else begin
            case (mode_ff)
               MODE_IDLE: begin
                  held_length_in = req_ch.rx_byte;
                  bytes_taken_in = '0;
                  tick_count_in  = '0;
                  mode_in = (req_ch.rx_byte <= max_length_ff) ? MODE_CMD : MODE_FLUSH;
               end
               MODE_CMD: begin
                  res_valid     = 1'b1;
                  res.event_res = lpfr_pkg::EV_HEADER;
                  res.command   = req_ch.rx_byte;
                  if (held_length_ff == '0) begin
                     res.last = 1'b1;
                     mode_in  = MODE_IDLE;
                  end else begin
                     bytes_taken_in = '0;
                     mode_in        = MODE_DATA;
                  end
               end
               MODE_DATA: begin
                  res_valid      = 1'b1;
                  res.event_res  = lpfr_pkg::EV_DATA;
                  res.data_byte  = req_ch.rx_byte;
                  res.byte_index = bytes_taken_ff;
                  bytes_taken_in = taken_next;
                  if (taken_next == held_length_ff) begin
                     res.last = 1'b1;
                     mode_in  = MODE_IDLE;
                  end
               end
               MODE_FLUSH: begin
                  // any byte restarts the idle gap
                  tick_count_in = '0;
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end
      end
   end

   // output register with one skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_fire) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_IDLE;
         held_length_ff     <= '0;
         bytes_taken_ff     <= '0;
         tick_count_ff      <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
         max_length_ff      <= lpfr_pkg::MAX_LENGTH_RST;
         message_timeout_ff <= lpfr_pkg::MESSAGE_TIMEOUT_RST;
         flush_idle_ff      <= lpfr_pkg::FLUSH_IDLE_RST;
      end else begin
         mode_ff        <= mode_in;
         held_length_ff <= held_length_in;
         bytes_taken_ff <= bytes_taken_in;
         tick_count_ff  <= tick_count_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               lpfr_pkg::CSR_MAX_LENGTH:      max_length_ff <= csr_ch.data[lpfr_pkg::BYTE_W-1:0];
               lpfr_pkg::CSR_MESSAGE_TIMEOUT: message_timeout_ff <= csr_ch.data;
               lpfr_pkg::CSR_FLUSH_IDLE:      flush_idle_ff <= csr_ch.data;
               default: begin
                  // unused index: drop the write
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.event_res    = out_ff.event_res;
   assign rsp_ch.frame_length = out_ff.frame_length;
   assign rsp_ch.command      = out_ff.command;
   assign rsp_ch.data_byte    = out_ff.data_byte;
   assign rsp_ch.byte_index   = out_ff.byte_index;
   assign rsp_ch.last         = out_ff.last;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ch.ready))
      else $error("skid register filled without a stalled output");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DATA) |-> (bytes_taken_ff < held_length_ff))
      else $error("payload count reached frame length without leaving payload mode");

   a_idle_exit: assert property (@(posedge clock) disable iff (reset)
      (req_fire && mode_ff == MODE_IDLE) |=> (mode_ff != MODE_DATA))
      else $error("jumped from idle straight to payload");

endmodule
